[rtl/bsa_pkg.sv]
// bsa_pkg: shared types and constants of the bitmap slot allocator
`default_nettype none

package bsa_pkg;

   localparam int ADDR_W       = 32;
   localparam int LOG_W        = 4;
   localparam int SLOT_FIELD_W = 6;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 32;

   localparam logic [LOG_W-1:0] SIZE_LOG2_RESET = 4'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_LOG2 = 1'd1;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NULL      = 3'd2,
      ST_OUTSIDE   = 3'd3,
      ST_NOT_ALLOC = 3'd4
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [ADDR_W-1:0]       block_address;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/bsa_lowest.sv]
// bsa_lowest: lowest set bit of the free map, as one-hot mask and index
`default_nettype none

module bsa_lowest #(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0]         map,
   output logic      [WIDTH-1:0]         onehot,
   output logic      [$clog2(WIDTH)-1:0] index,
   output logic                          found
);

   localparam int IDX_W = $clog2(WIDTH);

   assign onehot = map & (~map + WIDTH'(1));
   assign found  = |map;

   always_comb begin
      index = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (onehot[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/bitmap_slot_allocator_core.sv]
// bitmap_slot_allocator_core: fixed-size block allocator over a free bitmap
//
// req channel: one beat per request, kind allocate or free, with the address
// to free. rsp channel: exactly one beat per request, in request order, with
// status, slot and the allocated block address.
// csr port: index 0 pool base, index 1 log2 of the block size; the user must
// write it only while no request is in flight; the block does not enforce it.
// a request accepted into the request register is worked through the priority
// pick or the range check, and its result is registered in the rsp register.
// one request per cycle is sustained while the rsp beat is not stalled; the
// free map is read and updated as the result is registered, so the next
// request already sees its effect.
// a stalled rsp beat holds; the request register then fills and req_stall
// rises until the rsp beat is taken.
// reset (synchronous) empties both registers, marks every slot free, sets
// the pool base to 0 and the size log2 to 4.
`default_nettype none

module bitmap_slot_allocator_core #(
   parameter int SLOTS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire bsa_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output bsa_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [bsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import bsa_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int SPAN_W = $clog2(SLOTS + 1) + (1 << LOG_W);
   localparam int CMP_W  = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;

   logic [ADDR_W-1:0] pool_base_ff, pool_base_in;
   logic [LOG_W-1:0]  size_log2_ff, size_log2_in;
   logic [SLOTS-1:0]  free_map_ff, free_map_in;
   logic              in_valid_ff, in_valid_in;
   req_type           req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              take;
   logic              fire;
   logic [SLOTS-1:0]  pick_onehot;
   logic [SLOT_W-1:0] pick_index;
   logic              pick_found;
   logic [ADDR_W-1:0] offset;
   logic [CMP_W-1:0]  span;
   logic              in_pool;
   logic [ADDR_W-1:0] shifted;
   logic [SLOT_W-1:0] free_index;
   logic [SLOTS-1:0]  free_onehot;
   logic              slot_used;
   logic [ADDR_W-1:0] alloc_address;
   rsp_type           result;

   bsa_lowest #(
      .WIDTH (SLOTS)
   ) u_lowest (
      .map    (free_map_ff),
      .onehot (pick_onehot),
      .index  (pick_index),
      .found  (pick_found)
   );

   assign take      = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && take;
   assign req_stall = in_valid_ff && !take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // range check and slot decode of a free, and the address of an allocation
   assign offset        = req_ff.address - pool_base_ff;
   assign span          = CMP_W'(SLOTS) << size_log2_ff;
   assign in_pool       = CMP_W'(offset) < span;
   assign shifted       = offset >> size_log2_ff;
   assign free_index    = shifted[SLOT_W-1:0];
   assign free_onehot   = SLOTS'(1) << free_index;
   assign slot_used     = in_pool && !free_map_ff[free_index];
   assign alloc_address = pool_base_ff + (ADDR_W'(pick_index) << size_log2_ff);

   always_comb begin
      result.status        = ST_OK;
      result.slot          = '0;
      result.block_address = '0;
      free_map_in          = free_map_ff;
      if (req_ff.kind == KIND_ALLOC) begin
         if (pick_found) begin
            result.slot          = SLOT_FIELD_W'(pick_index);
            result.block_address = alloc_address;
            free_map_in          = free_map_ff & ~pick_onehot;
         end else begin
            result.status = ST_FULL;
         end
      end else if (req_ff.address == '0) begin
         result.status = ST_NULL;
      end else if (!in_pool) begin
         result.status = ST_OUTSIDE;
      end else if (!slot_used) begin
         result.status = ST_NOT_ALLOC;
      end else begin
         result.slot = SLOT_FIELD_W'(free_index);
         free_map_in = free_map_ff | free_onehot;
      end
      if (!fire) begin
         free_map_in = free_map_ff;
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            req_in = req_data;
         end
      end
      if (take) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            rsp_in = result;
         end
      end
   end

   always_comb begin
      pool_base_in = pool_base_ff;
      size_log2_in = size_log2_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_POOL_BASE: pool_base_in = csr_wdata[ADDR_W-1:0];
            CSR_SIZE_LOG2: size_log2_in = csr_wdata[LOG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         size_log2_ff <= SIZE_LOG2_RESET;
         free_map_ff  <= '1;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_base_ff <= pool_base_in;
         size_log2_ff <= size_log2_in;
         free_map_ff  <= free_map_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // every slot free straight after reset
   assert property (@(posedge clock) reset |=> free_map_ff == {SLOTS{1'b1}})
      else $error("free map not all free after reset");

   // at most one slot changes per cycle
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> $countones(free_map_ff ^ $past(free_map_ff)) <= 1)
      else $error("more than one slot changed in one cycle");

   // a granted allocation removes exactly one free slot
   assert property (@(posedge clock) disable iff (reset)
      fire && req_ff.kind == KIND_ALLOC && pick_found
      |=> $countones(free_map_ff) == $countones($past(free_map_ff)) - 1)
      else $error("allocation did not take exactly one slot");

endmodule

`default_nettype wire

[dv/bitmap_slot_allocator_core_tb.sv]
// bitmap_slot_allocator_core_tb: self-checking testbench for the bitmap slot allocator core
`default_nettype none

module bitmap_slot_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsa_pkg::*;

   localparam int NUM_SLOTS     = 64;
   localparam int NUM_SEGMENTS  = 6;
   localparam int SEGMENT_ITEMS = 240;
   localparam int CYCLE_LIMIT   = 400000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_POOL_BASE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // allocator state as the block should hold it
   logic [NUM_SLOTS-1:0] shadow_free_map = '1;
   logic [ADDR_W-1:0]    shadow_pool_base = '0;
   logic [LOG_W-1:0]     shadow_size_log2 = SIZE_LOG2_RESET;

   req_type request_queue[$];
   rsp_type pending_outcomes[$];
   rsp_type expected_beat;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures = 0;
   int cycle_count = 0;

   bitmap_slot_allocator_core #(.SLOTS(NUM_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic rsp_type slot_outcome(req_type r);
      rsp_type        o;
      logic [31:0]    offset;
      logic [32:0]    span;
      int             s;
      bit             found;
      o = '0;
      o.status = ST_OK;
      found = 1'b0;
      if (r.kind == KIND_ALLOC) begin
         for (s = 0; s < NUM_SLOTS; s++) begin
            if (!found && shadow_free_map[s]) begin
               found = 1'b1;
               shadow_free_map[s] = 1'b0;
               o.slot = s[SLOT_FIELD_W-1:0];
               o.block_address = shadow_pool_base + (32'(s) << shadow_size_log2);
            end
         end
         if (!found)
            o.status = ST_FULL;
      end else if (r.address == '0) begin
         o.status = ST_NULL;
      end else begin
         offset = r.address - shadow_pool_base;
         span = 33'(NUM_SLOTS) << shadow_size_log2;
         if ({1'b0, offset} >= span) begin
            o.status = ST_OUTSIDE;
         end else begin
            s = int'(offset >> shadow_size_log2);
            if (shadow_free_map[s]) begin
               o.status = ST_NOT_ALLOC;
            end else begin
               shadow_free_map[s] = 1'b1;
               o.slot = s[SLOT_FIELD_W-1:0];
            end
         end
      end
      return o;
   endfunction

   function automatic void queue_request(kind_type k, logic [ADDR_W-1:0] a);
      req_type r;
      r.kind = k;
      r.address = a;
      request_queue.push_back(r);
   endfunction

   // mostly addresses that land on a block of the pool, some null, outside or raw
   function automatic void queue_random_request(int alloc_pct);
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] block_mask;
      int                pick;
      kind_type          k;
      block_mask = (32'd1 << shadow_size_log2) - 32'd1;
      pick = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct)
         k = KIND_ALLOC;
      else
         k = KIND_FREE;
      if (pick < 70)
         a = shadow_pool_base + (32'($urandom_range(NUM_SLOTS - 1)) << shadow_size_log2)
             + (($urandom_range(3) == 0) ? ($urandom & block_mask) : 32'd0);
      else if (pick < 80)
         a = '0;
      else if (pick < 90)
         a = shadow_pool_base + (32'(NUM_SLOTS) << shadow_size_log2) + $urandom_range(255);
      else
         a = $urandom;
      queue_request(k, a);
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_POOL_BASE)
         shadow_pool_base = value;
      else
         shadow_size_log2 = value[LOG_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_drained();
      while (request_queue.size() != 0 || req_valid || pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            pending_outcomes.push_back(slot_outcome(req_data));
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= request_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $error("rsp beat with no request outstanding: %h", rsp_data);
               failures++;
            end else begin
               expected_beat = pending_outcomes.pop_front();
               if (rsp_data.status !== expected_beat.status) begin
                  $error("status: expected %0d, actual %0d",
                         expected_beat.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.slot !== expected_beat.slot) begin
                  $error("slot: expected %0d, actual %0d", expected_beat.slot, rsp_data.slot);
                  failures++;
               end
               if (rsp_data.block_address !== expected_beat.block_address) begin
                  $error("block_address: expected %h, actual %h",
                         expected_beat.block_address, rsp_data.block_address);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [ADDR_W-1:0] seg_base[NUM_SEGMENTS];
      logic [LOG_W-1:0]  seg_log2[NUM_SEGMENTS];
      int                seg_alloc_pct[NUM_SEGMENTS];
      int                seg;
      int                n;
      seg_base = '{32'h0000_0000, 32'hFFFF_FFE0, $urandom, 32'hFFFF_0000,
                   $urandom & 32'hFFFF_FFF0, 32'hFFFF_FFFF};
      seg_log2 = '{4'd4, 4'd0, 4'd12, 4'd15, 4'($urandom_range(12)), 4'd1};
      seg_alloc_pct = '{80, 30, 65, 40, 75, 45};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
         write_csr(CSR_POOL_BASE, seg_base[seg]);
         write_csr(CSR_SIZE_LOG2, CSR_DATA_W'(seg_log2[seg]));
         send_idle_pct = (seg < 2) ? 21 : (seg < 4) ? 70 : 0;
         recv_idle_pct = (seg < 2) ? 70 : (seg < 4) ? 21 : 0;
         if (seg == 0) begin
            // null free while the pool covers address zero
            queue_request(KIND_FREE, 32'h0000_0000);
            queue_request(KIND_FREE, 32'h0000_0010);
            queue_request(KIND_ALLOC, 32'hFFFF_FFFF);
            queue_request(KIND_ALLOC, 32'h0000_0000);
            queue_request(KIND_ALLOC, 32'h1234_5678);
            queue_request(KIND_FREE, 32'h0000_0010);
            // double free through an offset inside the block
            queue_request(KIND_FREE, 32'h0000_001F);
            queue_request(KIND_FREE, 32'h0000_0400);
            queue_request(KIND_FREE, 32'hFFFF_FFFF);
            queue_request(KIND_FREE, 32'h8000_0000);
            queue_request(KIND_ALLOC, 32'h0000_0000);
            queue_request(KIND_FREE, 32'h0000_0020);
            queue_request(KIND_FREE, 32'h0000_03FF);
            queue_request(KIND_ALLOC, 32'h0000_0000);
            queue_request(KIND_FREE, 32'h0000_0000);
         end
         for (n = 0; n < SEGMENT_ITEMS; n++)
            queue_random_request(seg_alloc_pct[seg]);
         wait_drained();
      end
      repeat (8) @(posedge clock);
      if (failures == 0 && pending_outcomes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
